// ===== design/lbp_tcs_pkg.sv =====
// Shared types and constants for the local binary pattern code stream unit.
package lbp_tcs_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int ROW_W      = 12;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Operation codes of an input item.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [SAMPLE_W-1:0] green_sample;
  } pixel_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] lbp_code;
    logic                last_of_frame;
  } code_t;

  // Per-item control decided when the item enters.
  typedef struct packed {
    logic emit;
    logic inner;
    logic last;
  } tag_t;

endpackage

// ===== design/lbp_tcs_row_mem.sv =====
// Two-row sample store: one write and one registered read per cycle, new data on collision.
module lbp_tcs_row_mem import lbp_tcs_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [2*SAMPLE_W-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [2*SAMPLE_W-1:0] rd_data
);

  logic [2*SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ===== design/lbp_tcs_ctrl.sv =====
// Frame geometry registers and the input and output position counters.
module lbp_tcs_ctrl import lbp_tcs_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int COL_W     = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  output logic [COL_W-1:0]      col,
  output tag_t                  tag
);

  function automatic logic [COL_W-1:0] width_last(input logic [CFG_DATA_W-1:0] d);
    int v;
    v = int'(d);
    if (v < 3) begin
      v = 3;
    end else if (v > MAX_WIDTH) begin
      v = MAX_WIDTH;
    end
    return COL_W'(v - 1);
  endfunction

  function automatic logic [ROW_W-1:0] height_last(input logic [CFG_DATA_W-1:0] d);
    logic [ROW_W-1:0] r;
    if (d < CFG_DATA_W'(3)) begin
      r = ROW_W'(2);
    end else begin
      r = ROW_W'(d) - ROW_W'(1);
    end
    return r;
  endfunction

  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;
  logic [COL_W-1:0] in_col;
  logic [1:0]       in_row;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;

  logic emit;
  logic last;
  logic inner;

  // Results start once width+1 items have entered the frame.
  assign emit  = (in_row == 2'd2) || ((in_row == 2'd1) && (in_col != '0));
  assign last  = (out_row == h_last) && (out_col == w_last);
  assign inner = (out_row != '0) && (out_row != h_last) &&
                 (out_col != '0) && (out_col != w_last);

  assign col = in_col;
  assign tag = '{emit: emit, inner: inner, last: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last  <= width_last(CFG_DATA_W'(640));
      h_last  <= height_last(CFG_DATA_W'(480));
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  w_last <= width_last(cfg_data);
        REG_FRAME_HEIGHT: h_last <= height_last(cfg_data);
        default: ;
      endcase
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept) begin
      if (emit && last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (in_col == w_last) begin
          in_col <= '0;
          if (in_row != 2'd2) begin
            in_row <= in_row + 2'd1;
          end
        end else begin
          in_col <= in_col + COL_W'(1);
        end
        if (emit) begin
          if (out_col == w_last) begin
            out_col <= '0;
            out_row <= out_row + ROW_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end
    end
  end

endmodule

// ===== design/lbp_tcs_window.sv =====
// Sliding 3x3 window and the eight neighbour comparisons that form the pattern code.
module lbp_tcs_window import lbp_tcs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic [SAMPLE_W-1:0] above2,
  input  logic [SAMPLE_W-1:0] above1,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [SAMPLE_W-1:0] pattern
);

  // Only the middle and right columns are kept; the left one drops out on a shift.
  logic [SAMPLE_W-1:0] mid   [3];
  logic [SAMPLE_W-1:0] right [3];
  logic [SAMPLE_W-1:0] centre;

  assign centre = right[1];

  always_comb begin
    pattern[7] = mid[0]   > centre;
    pattern[6] = right[0] > centre;
    pattern[5] = above2   > centre;
    pattern[4] = mid[1]   > centre;
    pattern[3] = above1   > centre;
    pattern[2] = sample   > centre;
    pattern[1] = right[2] > centre;
    pattern[0] = mid[2]   > centre;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        mid[r]   <= '0;
        right[r] <= '0;
      end
    end else if (shift) begin
      for (int r = 0; r < 3; r++) begin
        mid[r] <= right[r];
      end
      right[0] <= above2;
      right[1] <= above1;
      right[2] <= sample;
    end
  end

endmodule

// ===== design/lbp_texture_code_stream_unit.sv =====
// Top level of the 3x3 local binary pattern code stream unit.
// Green samples enter in raster order, one per transfer, and leave as one 8-bit local binary
// pattern code per pixel, also in raster order; a bit is set when its neighbour is strictly
// greater than the centre (bit 7 top-left, 6 top, 5 top-right, 4 left, 3 right, 2 bottom-right,
// 1 bottom, 0 bottom-left) and pixels on the frame border give zero. Codes lag the samples by
// frame_width+1 items, so after the last pixel the host sends frame_width+1 drain items
// (operation set); the code of the final pixel carries last_of_frame, after which the next item
// starts a new frame. The unit takes one item per clock and keeps that rate as long as codes are
// taken; a code is formed by the registered read of the row store and then the window comparison
// into the output register. The row store is a single memory of MAX_WIDTH entries holding the
// two rows above the current one, read and written once per item. Writing either geometry
// register restarts the frame; a width outside 3 to MAX_WIDTH is clamped, as is a height below 3.
// Configuration must be written only while the unit is idle; the unit itself does not enforce it.
// The row store needs no clearing after reset, as unwritten entries only reach border codes.
module lbp_texture_code_stream_unit import lbp_tcs_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  pixel_t                pixel,
  output logic                  code_valid,
  input  logic                  code_ready,
  output code_t                 code,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                  accept;
  logic [COL_W-1:0]      ctrl_col;
  tag_t                  ctrl_tag;

  // Stage between the pixel transfer and the window: the row store read is in flight here.
  logic                  s1_valid;
  tag_t                  s1_tag;
  logic [COL_W-1:0]      s1_col;
  logic [SAMPLE_W-1:0]   s1_sample;
  logic                  s1_adv;

  logic [2*SAMPLE_W-1:0] rows_rd;
  logic [SAMPLE_W-1:0]   pattern;

  // The stage moves on when its item makes no code or the output register is free or emptying.
  assign s1_adv      = s1_valid && (!s1_tag.emit || !code_valid || code_ready);
  assign pixel_ready = !s1_valid || s1_adv;
  assign accept      = pixel_valid && pixel_ready;

  lbp_tcs_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .col       (ctrl_col),
    .tag       (ctrl_tag)
  );

  // Each entry holds the older row in the upper byte and the newer row in the lower byte.
  // Writing back shifts the newer sample into the older slot and the fresh sample into the newer.
  lbp_tcs_row_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W)
  ) u_rows (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data ({rows_rd[SAMPLE_W-1:0], s1_sample}),
    .rd_en   (accept),
    .rd_addr (ctrl_col),
    .rd_data (rows_rd)
  );

  lbp_tcs_window u_window (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_adv),
    .above2  (rows_rd[2*SAMPLE_W-1:SAMPLE_W]),
    .above1  (rows_rd[SAMPLE_W-1:0]),
    .sample  (s1_sample),
    .pattern (pattern)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // A drain step enters the window as a zero sample.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag    <= ctrl_tag;
      s1_col    <= ctrl_col;
      s1_sample <= (pixel.operation == OP_DRAIN) ? '0 : pixel.green_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (s1_adv && s1_tag.emit) begin
      code_valid <= 1'b1;
    end else if (code_ready) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_tag.emit) begin
      code.lbp_code      <= s1_tag.inner ? pattern : '0;
      code.last_of_frame <= s1_tag.last;
    end
  end

  // A code only appears after an item that makes one has left the first stage.
  a_code_source: assert property (@(posedge clk) disable iff (rst)
    $rose(code_valid) |-> $past(s1_adv && s1_tag.emit))
    else $error("code became valid without a producing item");

  // The frame's last pixel always lies on the border and always makes a code.
  a_last_border: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_tag.last |-> s1_tag.emit && !s1_tag.inner)
    else $error("last pixel tagged as inner or without a code");

  // A full output register that is not taken blocks a producing item and new pixels.
  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_ready && s1_valid && s1_tag.emit |-> !pixel_ready)
    else $error("pixel accepted while the pipeline is stalled");

endmodule
